// File: hw/rtl/ftnc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frequency table nibble compressor.
// No dependencies.
package ftnc_pkg;

    // Input item kinds, carried on s_axis_tuser
    typedef enum logic [1:0] {
        KIND_COUNT  = 2'd0,
        KIND_BUILD  = 2'd1,
        KIND_ENCODE = 2'd2,
        KIND_FLUSH  = 2'd3
    } kind_t;

    // Table slots below this value encode as a single nibble
    localparam int ONE_NIB_SLOTS = 14;
    localparam int SYMBOLS       = 256;

endpackage

// File: hw/rtl/frequency_table_nibble_compressor.sv
`timescale 1ns / 1ps
// Frequency table nibble compressor: histogram, table build and nibble encoder.
// Depends on ftnc_pkg.
//
// Usage: the input channel (s_axis) carries one item per transaction, the kind
// on tuser and the byte on tdata. Count items add the byte to a 256-entry
// histogram held in a registered-read RAM (read, then write back). Build
// items scan the histogram once per table slot and send TABLE_SIZE table bytes
// on m_axis with tuser high; the histogram is then cleared at once by its
// valid bits. Encode items match the byte against the table and send 0 to 2
// packed bytes; flush items send a pending half byte padded with zero.
// tlast marks the final result transaction of each input item.
// Encode and flush items pack up to 3 nibbles; a build item's pace is set by the
// one-read-per-cycle scan of the histogram RAM, once per table slot.
// The output register lets one result wait while the block goes on; when the
// receiver stalls with a result still held, the block waits before the next.
// Reset clears the histogram valid bits, table, pending nibble and output.
module frequency_table_nibble_compressor #(
    parameter int TABLE_SIZE  = 30,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] is_table_entry
    output logic       m_axis_tlast
);
    import ftnc_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_SCAN,
        S_PICK,
        S_ENC
    } state_t;

    state_t state_reg;

    // Histogram RAM and its valid bits
    logic [COUNT_WIDTH-1:0] hist_mem [SYMBOLS];
    logic [COUNT_WIDTH-1:0] mem_q_reg;
    logic [SYMBOLS-1:0]     hist_valid_reg;
    logic                   vq_reg;
    logic [7:0]             rd_addr;
    logic                   hist_we;
    logic [7:0]             hist_wa;
    logic [COUNT_WIDTH-1:0] hist_wd;
    logic                   clr_one;
    logic                   clr_all;
    logic [COUNT_WIDTH-1:0] hval;

    // Build scan
    logic [8:0]             scan_cnt_reg;
    logic                   rd_vld_reg;
    logic [7:0]             rd_idx_reg;
    logic [7:0]             best_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [7:0]             table_reg [TABLE_SIZE];

    // Nibble sequencer
    logic [3:0] nib_reg [3];
    logic [1:0] nib_idx_reg;
    logic [1:0] nib_cnt_reg;
    logic [1:0] nib_rem;
    logic [3:0] pend_nib_reg;
    logic       pend_flag_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_tab_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       out_load;

    // Table match
    logic              hit;
    logic [SLOT_W-1:0] match_slot;
    logic [SLOT_W:0]   slot_plus;
    logic [SLOT_W:0]   slot_minus;

    logic accept;
    kind_t in_kind;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_kind       = kind_t'(s_axis_tuser);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = out_free && ((state_reg == S_PICK) ||
                                        ((state_reg == S_ENC) && pend_flag_reg));
    assign hval          = vq_reg ? mem_q_reg : '0;
    assign nib_rem       = nib_cnt_reg - nib_idx_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_tab_reg;
    assign m_axis_tlast  = out_last_reg;

    // First matching table slot
    always_comb
    begin
        hit        = 1'b0;
        match_slot = '0;
        for (int j = TABLE_SIZE - 1; j >= 0; j--)
        begin
            if (table_reg[j] == s_axis_tdata)
            begin
                hit        = 1'b1;
                match_slot = SLOT_W'(j);
            end
        end
        slot_plus  = {1'b0, match_slot} + (SLOT_W+1)'(2);
        slot_minus = {1'b0, match_slot} - (SLOT_W+1)'(ONE_NIB_SLOTS);
    end

    // Histogram port control
    always_comb
    begin
        rd_addr = (state_reg == S_SCAN) ? scan_cnt_reg[7:0] : s_axis_tdata;
        hist_we = (state_reg == S_CNT) && (hval != COUNT_MAX);
        hist_wa = rd_idx_reg;
        hist_wd = hval + COUNT_WIDTH'(1);
        clr_one = (state_reg == S_PICK) && out_free;
        clr_all = clr_one && (slot_reg == SLOT_W'(TABLE_SIZE - 1));
    end

    // Histogram RAM, one read and one write a cycle
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        mem_q_reg <= hist_mem[rd_addr];
    end

    // Valid bits: an entry not valid reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
            vq_reg         <= 1'b0;
        end
        else
        begin
            vq_reg <= hist_valid_reg[rd_addr];
            if (clr_all)
            begin
                hist_valid_reg <= '0;
            end
            else
            begin
                if (hist_we)
                begin
                    hist_valid_reg[hist_wa] <= 1'b1;
                end
                if (clr_one)
                begin
                    hist_valid_reg[best_reg] <= 1'b0;
                end
            end
        end
    end

    // Control state machine and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            best_reg      <= '0;
            best_cnt_reg  <= '0;
            slot_reg      <= '0;
            nib_idx_reg   <= '0;
            nib_cnt_reg   <= '0;
            pend_nib_reg  <= '0;
            pend_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_tab_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int j = 0; j < TABLE_SIZE; j++)
            begin
                table_reg[j] <= '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                nib_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    rd_idx_reg  <= s_axis_tdata;
                    nib_idx_reg <= '0;
                    if (accept)
                    begin
                        case (in_kind)
                            KIND_COUNT:
                            begin
                                state_reg <= S_CNT;
                            end
                            KIND_BUILD:
                            begin
                                slot_reg     <= '0;
                                scan_cnt_reg <= '0;
                                rd_vld_reg   <= 1'b0;
                                best_reg     <= '0;
                                best_cnt_reg <= '0;
                                state_reg    <= S_SCAN;
                            end
                            KIND_ENCODE:
                            begin
                                state_reg <= S_ENC;
                                if (!hit)
                                begin
                                    nib_reg[0]  <= 4'h0;
                                    nib_reg[1]  <= s_axis_tdata[3:0];
                                    nib_reg[2]  <= s_axis_tdata[7:4];
                                    nib_cnt_reg <= 2'd3;
                                end
                                else if (match_slot >= SLOT_W'(ONE_NIB_SLOTS))
                                begin
                                    nib_reg[0]  <= 4'h1;
                                    nib_reg[1]  <= slot_minus[3:0];
                                    nib_cnt_reg <= 2'd2;
                                end
                                else
                                begin
                                    nib_reg[0]  <= slot_plus[3:0];
                                    nib_cnt_reg <= 2'd1;
                                end
                            end
                            default:
                            begin
                                // flush: pad only when half a byte waits
                                if (pend_flag_reg)
                                begin
                                    nib_reg[0]  <= 4'h0;
                                    nib_cnt_reg <= 2'd1;
                                    state_reg   <= S_ENC;
                                end
                            end
                        endcase
                    end
                end
                S_CNT:
                begin
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // issue one read a cycle, compare in the cycle after
                    rd_vld_reg <= !scan_cnt_reg[8];
                    if (!scan_cnt_reg[8])
                    begin
                        rd_idx_reg   <= scan_cnt_reg[7:0];
                        scan_cnt_reg <= scan_cnt_reg + 9'd1;
                    end
                    if (rd_vld_reg)
                    begin
                        if (hval > best_cnt_reg)
                        begin
                            best_cnt_reg <= hval;
                            best_reg     <= rd_idx_reg;
                        end
                        if (rd_idx_reg == 8'hFF)
                        begin
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_PICK:
                begin
                    if (out_free)
                    begin
                        out_byte_reg        <= best_reg;
                        out_tab_reg         <= 1'b1;
                        out_last_reg        <= clr_all;
                        table_reg[slot_reg] <= best_reg;
                        scan_cnt_reg        <= '0;
                        rd_vld_reg          <= 1'b0;
                        best_reg            <= '0;
                        best_cnt_reg        <= '0;
                        slot_reg            <= slot_reg + SLOT_W'(1);
                        state_reg           <= clr_all ? S_IDLE : S_SCAN;
                    end
                end
                S_ENC:
                begin
                    // one nibble a cycle; a completed byte needs a free output
                    if (!pend_flag_reg)
                    begin
                        pend_nib_reg  <= nib_reg[nib_idx_reg];
                        pend_flag_reg <= 1'b1;
                        nib_idx_reg   <= nib_idx_reg + 2'd1;
                        if (nib_rem == 2'd1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (out_free)
                    begin
                        out_byte_reg  <= {pend_nib_reg, nib_reg[nib_idx_reg]};
                        out_tab_reg   <= 1'b0;
                        out_last_reg  <= (nib_rem != 2'd3);
                        pend_nib_reg  <= '0;
                        pend_flag_reg <= 1'b0;
                        nib_idx_reg   <= nib_idx_reg + 2'd1;
                        if (nib_rem == 2'd1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A count update always follows directly from an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CNT |-> $past(state_reg) == S_IDLE)
        else $error("count update without accepted item");

    // The nibble index never runs past the nibble count while encoding
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ENC |-> nib_idx_reg < nib_cnt_reg)
        else $error("nibble index overrun");

    // A table transaction ends its item only on the final table slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_tab_reg && out_last_reg && $changed(out_byte_reg)
            |-> state_reg == S_IDLE && $past(slot_reg) == SLOT_W'(TABLE_SIZE - 1))
        else $error("table tlast off the final slot");

    // After a build the histogram holds no valid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_all |=> hist_valid_reg == '0)
        else $error("histogram not cleared after build");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for frequency_table_nibble_compressor: directed and random items,
// results checked against a built-in model of histogram, table and nibble packer.
// Depends on ftnc_pkg and the compressor RTL.
module testbench;
    import ftnc_pkg::*;

    localparam int TBL = 30;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       is_tab;
        logic       last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    // Model state
    logic [CNT_W-1:0] hist_cnt [256];
    logic [7:0] tbl_bytes [TBL];
    logic [3:0] held_nib;
    logic held_flag;
    result_t expected_results[$];
    int errors = 0;
    int burst_left = 0;

    frequency_table_nibble_compressor #(.TABLE_SIZE(TBL), .COUNT_WIDTH(CNT_W)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pack one nibble; a completed byte joins the expected queue
    task automatic pack_nibble(input logic [3:0] nib, inout int n);
        if (held_flag)
        begin
            expected_results.push_back('{data: {held_nib, nib}, is_tab: 1'b0, last: 1'b0});
            held_flag = 1'b0;
            held_nib = '0;
            n++;
        end
        else
        begin
            held_nib = nib;
            held_flag = 1'b1;
        end
    endtask

    // Predict the results of one compressor item
    task automatic predict_compressor(input kind_t kind, input logic [7:0] b);
        int n;
        int best;
        int slot;
        n = 0;
        case (kind)
            KIND_COUNT:
                if (hist_cnt[b] < CNT_MAX) hist_cnt[b]++;
            KIND_BUILD:
            begin
                for (int j = 0; j < TBL; j++)
                begin
                    best = 0;
                    for (int i = 1; i < SYMBOLS; i++)
                        if (hist_cnt[i] > hist_cnt[best]) best = i;
                    tbl_bytes[j] = best[7:0];
                    hist_cnt[best] = '0;
                    expected_results.push_back('{data: best[7:0], is_tab: 1'b1, last: 1'b0});
                    n++;
                end
                for (int i = 0; i < SYMBOLS; i++) hist_cnt[i] = '0;
            end
            KIND_ENCODE:
            begin
                slot = TBL;
                for (int j = TBL - 1; j >= 0; j--)
                    if (tbl_bytes[j] == b) slot = j;
                if (slot == TBL)
                begin
                    pack_nibble(4'h0, n);
                    pack_nibble(b[3:0], n);
                    pack_nibble(b[7:4], n);
                end
                else if (slot >= ONE_NIB_SLOTS)
                begin
                    pack_nibble(4'h1, n);
                    pack_nibble(4'(slot - ONE_NIB_SLOTS), n);
                end
                else
                    pack_nibble(4'(slot + 2), n);
            end
            default:
                if (held_flag) pack_nibble(4'h0, n);
        endcase
        if (n > 0) expected_results[$].last = 1'b1;
    endtask

    // Send one transaction, with bursts and random gaps; tvalid drops only in a gap
    task automatic send_item(input kind_t kind, input logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_compressor(kind, b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= b;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Receiver stall pattern: ready at random three times in four, stalled otherwise
    initial
    begin
        forever
        begin
            @(posedge clk);
            case ($urandom_range(0, 3))
                0: m_axis_tready <= 1'b0;
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: data %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata !== exp_r.data)
                begin
                    $error("out_byte: expected %h actual %h", exp_r.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.is_tab)
                begin
                    $error("is_table_entry: expected %b actual %b", exp_r.is_tab, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_r.last)
                begin
                    $error("last: expected %b actual %b", exp_r.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Encode and flush against the reset table, all field extremes
    task automatic test_before_build();
        send_item(KIND_ENCODE, 8'h00);
        send_item(KIND_ENCODE, 8'hFF);
        send_item(KIND_FLUSH, 8'h00);
        send_item(KIND_FLUSH, 8'hA5);
        send_item(KIND_ENCODE, 8'h5A);
        send_item(KIND_FLUSH, 8'h00);
    endtask

    // Build with ties, empty slots, then encode across all slot ranges
    task automatic test_build_and_encode();
        for (int i = 0; i < 16; i++)
            repeat (i % 3 + 1) send_item(KIND_COUNT, 8'(8'hF0 + i));
        send_item(KIND_COUNT, 8'h01);
        send_item(KIND_BUILD, 8'h00);
        send_item(KIND_ENCODE, 8'hF2);
        send_item(KIND_ENCODE, 8'hF0);
        send_item(KIND_ENCODE, 8'h01);
        send_item(KIND_ENCODE, 8'h00);
        send_item(KIND_ENCODE, 8'h77);
        send_item(KIND_FLUSH, 8'h00);
    endtask

    // Repeated counts on one byte, then build so that byte wins slot 0
    task automatic test_dominant_byte();
        repeat (20) send_item(KIND_COUNT, 8'h3C);
        send_item(KIND_COUNT, 8'h3D);
        send_item(KIND_BUILD, 8'h00);
        send_item(KIND_ENCODE, 8'h3C);
        send_item(KIND_FLUSH, 8'h00);
    endtask

    // Random passes: skewed counts, one build, then encodes mixed with noise
    task automatic test_random();
        logic [7:0] b;
        for (int pass = 0; pass < 3; pass++)
        begin
            repeat ($urandom_range(10, 25))
            begin
                b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
                send_item(KIND_COUNT, b);
            end
            send_item(KIND_BUILD, 8'($urandom));
            repeat ($urandom_range(15, 30))
            begin
                b = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
                case ($urandom_range(0, 9))
                    0: send_item(KIND_FLUSH, 8'($urandom));
                    1: send_item(KIND_COUNT, b);
                    default: send_item(KIND_ENCODE, b);
                endcase
            end
            send_item(KIND_FLUSH, 8'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < SYMBOLS; i++) hist_cnt[i] = '0;
        for (int j = 0; j < TBL; j++) tbl_bytes[j] = '0;
        held_nib = '0;
        held_flag = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_build();
        test_build_and_encode();
        test_dominant_byte();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #20000000;
        $display("testbench failed");
        $finish;
    end
endmodule
